@@ hdl/ule_pkg.sv @@
// Shared types, character codes and echo-text helpers for the UART line editor.
`timescale 1ns / 1ps
`default_nettype none

package ule_pkg;

   localparam int FILL_W = 5;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7e;
   localparam logic [7:0] CH_DEL    = 8'h7f;
   localparam logic [7:0] CH_CTRL_W = 8'h17;
   localparam logic [7:0] CH_CTRL_U = 8'h15;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7a;
   localparam logic [7:0] CASE_MASK = 8'hdf;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_MARK = 2'd2;

   localparam logic [4:0] ERR_LAST = 5'd31;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_error;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic [3:0] line_length;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NEWLINE,
      ST_FLUSH_RD,
      ST_FLUSH_CHAR,
      ST_ERASE,
      ST_WORD_RD,
      ST_WORD_SPACE,
      ST_TAB,
      ST_ERROR
   } state_type;

   typedef enum logic [1:0] {
      ERASE_ONE,
      ERASE_ALL,
      ERASE_WORD
   } erase_type;

   function automatic logic [7:0] normalize(input req_type r);
      logic [7:0] c;
      c = r.rx_byte;
      if (r.frame_error || c == CH_CR || c == CH_ESC) begin
         c = CH_LF;
      end
      if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         c = c & CASE_MASK;
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v > 4'd9) begin
         return 8'h41 + 8'(v - 4'd10);
      end
      return 8'h30 + 8'(v);
   endfunction

   // Error echo: CR LF, the message text, two hex digits, CR LF.
   function automatic logic [7:0] err_echo(input logic [4:0] idx, input logic [7:0] c);
      logic [7:0] b;
      case (idx)
         5'd0:  b = CH_CR;
         5'd1:  b = CH_LF;
         5'd2:  b = 8'h45;
         5'd3:  b = 8'h3a;
         5'd4:  b = CH_SP;
         5'd5:  b = 8'h6e;
         5'd6:  b = 8'h6f;
         5'd7:  b = 8'h6e;
         5'd8:  b = 8'h2d;
         5'd9:  b = 8'h76;
         5'd10: b = 8'h61;
         5'd11: b = 8'h6c;
         5'd12: b = 8'h69;
         5'd13: b = 8'h64;
         5'd14: b = CH_SP;
         5'd15: b = 8'h6b;
         5'd16: b = 8'h65;
         5'd17: b = 8'h79;
         5'd18: b = CH_SP;
         5'd19: b = 8'h63;
         5'd20: b = 8'h6f;
         5'd21: b = 8'h64;
         5'd22: b = 8'h65;
         5'd23: b = CH_SP;
         5'd24: b = 8'h68;
         5'd25: b = 8'h65;
         5'd26: b = 8'h78;
         5'd27: b = 8'h3d;
         5'd28: b = hex_digit(c[7:4]);
         5'd29: b = hex_digit(c[3:0]);
         5'd30: b = CH_CR;
         5'd31: b = CH_LF;
         default: b = CH_LF;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hdl/uart_line_editor.sv @@
// Line editor: byte decode, line memory, echo and completed-line output.
// Order: a printable byte is echoed from the decode state; other bytes move on to a handling
// state first, and a word erase first passes the word read and space check states.
// Results: one per cycle while the receiver takes them, but a line flush reads each stored
// character from the line memory before it is sent; no new request is taken until idle.
// Reset clears the fill count, the state machine and the output valid flag, not the output data or the memory.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_editor
   import ule_pkg::*;
#(
   parameter int LINE_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_DEPTH - 1);

   logic [7:0] line_mem [LINE_DEPTH];
   logic [7:0] rd_data_ff;

   state_type         state_ff, state_in;
   erase_type         mode_ff, mode_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [7:0]        c_ff, c_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              can_emit;
   logic              emit;
   rsp_type           emit_data;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [FILL_W-1:0] fill_m1, fill_m2, fill_p1;
   logic              full;
   logic              word_more;
   logic              tab_more;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign fill_m1   = fill_ff - FILL_W'(1);
   assign fill_m2   = fill_ff - FILL_W'(2);
   assign fill_p1   = fill_ff + FILL_W'(1);
   assign full      = (fill_ff >= FILL_LIMIT);
   assign word_more = (fill_ff > FILL_W'(1)) && (rd_data_ff != CH_SP);
   assign tab_more  = (fill_p1 < FILL_LIMIT) && (fill_p1[2:0] != 3'd0);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= line_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= ERASE_ONE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      c_in      = c_ff;
      emit      = 1'b0;
      emit_data = '0;
      mem_we    = 1'b0;
      mem_waddr = fill_ff[AW-1:0];
      mem_wdata = c_ff;
      mem_re    = 1'b0;
      mem_raddr = fill_m1[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               c_in     = normalize(req_data);
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in = '0;
            if (full || c_ff == CH_LF) begin
               state_in = ST_NEWLINE;
            end else if (c_ff == CH_BS || c_ff == CH_DEL) begin
               mode_in  = ERASE_ONE;
               state_in = (fill_ff == '0) ? ST_IDLE : ST_ERASE;
            end else if (c_ff == CH_CTRL_W) begin
               state_in = (fill_ff == '0) ? ST_IDLE : ST_WORD_RD;
            end else if (c_ff == CH_CTRL_U) begin
               mode_in  = ERASE_ALL;
               state_in = (fill_ff == '0) ? ST_IDLE : ST_ERASE;
            end else if (c_ff == CH_TAB) begin
               state_in = ST_TAB;
            end else if (c_ff >= CH_SP && c_ff <= CH_TILDE) begin
               if (can_emit) begin
                  emit               = 1'b1;
                  emit_data.out_byte = c_ff;
                  emit_data.out_kind = KIND_ECHO;
                  emit_data.last     = 1'b1;
                  mem_we             = 1'b1;
                  fill_in            = fill_p1;
                  state_in           = ST_IDLE;
               end
            end else begin
               state_in = ST_ERROR;
            end
         end
         ST_NEWLINE: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_data.out_byte = (cnt_ff == '0) ? CH_LF : CH_CR;
               emit_data.out_kind = KIND_ECHO;
               if (cnt_ff == '0) begin
                  cnt_in = 5'd1;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_FLUSH_RD;
               end
            end
         end
         ST_FLUSH_RD: begin
            if (FILL_W'(cnt_ff) < fill_ff) begin
               mem_re    = 1'b1;
               mem_raddr = cnt_ff[AW-1:0];
               state_in  = ST_FLUSH_CHAR;
            end else if (can_emit) begin
               emit                  = 1'b1;
               emit_data.out_kind    = KIND_MARK;
               emit_data.line_length = fill_ff[3:0];
               emit_data.last        = 1'b1;
               fill_in               = '0;
               state_in              = ST_IDLE;
            end
         end
         ST_FLUSH_CHAR: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_data.out_byte = rd_data_ff;
               emit_data.out_kind = KIND_CHAR;
               cnt_in             = cnt_ff + 5'd1;
               state_in           = ST_FLUSH_RD;
            end
         end
         ST_ERASE: begin
            if (cnt_ff == '0 && mode_ff == ERASE_WORD && fill_ff > FILL_W'(1)) begin
               mem_re    = 1'b1;
               mem_raddr = fill_m2[AW-1:0];
            end
            if (can_emit) begin
               emit               = 1'b1;
               emit_data.out_byte = (cnt_ff == 5'd1) ? CH_SP : CH_BS;
               emit_data.out_kind = KIND_ECHO;
               if (cnt_ff == 5'd2) begin
                  fill_in = fill_m1;
                  cnt_in  = '0;
                  case (mode_ff)
                     ERASE_ALL: begin
                        emit_data.last = (fill_ff == FILL_W'(1));
                     end
                     ERASE_WORD: begin
                        emit_data.last = !word_more;
                     end
                     default: begin
                        emit_data.last = 1'b1;
                     end
                  endcase
                  if (emit_data.last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cnt_in = cnt_ff + 5'd1;
               end
            end
         end
         ST_WORD_RD: begin
            mem_re   = 1'b1;
            state_in = ST_WORD_SPACE;
         end
         ST_WORD_SPACE: begin
            if (rd_data_ff == CH_SP) begin
               if (can_emit) begin
                  emit               = 1'b1;
                  emit_data.out_byte = CH_BS;
                  emit_data.out_kind = KIND_ECHO;
                  emit_data.last     = (fill_ff == FILL_W'(1));
                  fill_in            = fill_m1;
                  if (fill_ff == FILL_W'(1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = fill_m2[AW-1:0];
                  end
               end
            end else begin
               mode_in  = ERASE_WORD;
               cnt_in   = '0;
               state_in = ST_ERASE;
            end
         end
         ST_TAB: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_data.out_byte = CH_SP;
               emit_data.out_kind = KIND_ECHO;
               mem_we             = 1'b1;
               mem_wdata          = CH_SP;
               fill_in            = fill_p1;
               if (!tab_more) begin
                  if (fill_p1 >= FILL_LIMIT) begin
                     cnt_in   = '0;
                     state_in = ST_FLUSH_RD;
                  end else begin
                     emit_data.last = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end
            end
         end
         ST_ERROR: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_data.out_byte = err_echo(cnt_ff, c_ff);
               emit_data.out_kind = KIND_ECHO;
               emit_data.last     = (cnt_ff == ERR_LAST);
               cnt_in             = cnt_ff + 5'd1;
               if (cnt_ff == ERR_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/ule_chk.sv @@
// Port-level assertions for the UART line editor and their bind statement.
`timescale 1ns / 1ps
`default_nettype none

module ule_chk
   import ule_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A stalled result must hold its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result changed or dropped while stalled.");

   // The editor works on one request at a time.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request accepted while another is in progress.");

   // A line end marker carries a zero byte and always closes its request.
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_MARK |->
         rsp_data.out_byte == 8'h00 && rsp_data.last)
      else $error("Malformed line end marker.");

   // Only the marker carries a length, and no other kind code appears.
   a_kind_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind != KIND_MARK |->
         rsp_data.line_length == 4'd0 &&
         (rsp_data.out_kind == KIND_ECHO || rsp_data.out_kind == KIND_CHAR))
      else $error("Bad kind code or stray line length.");

   // Line characters are never the final result of a request.
   a_char_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_CHAR |-> !rsp_data.last)
      else $error("Line character flagged as last result.");

endmodule

bind uart_line_editor ule_chk u_ule_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
